// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the step sequencer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// types, codes and helpers shared by the step sequencer modules
// ----------------------------------------------------------------------------
package sps_pkg;

   // item kinds carried in tuser
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_SCAN  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_TICKS_PER_STEP = 3'd0;
   localparam logic [2:0] REG_GATE_OFF_TICK  = 3'd1;
   localparam logic [2:0] REG_CV_BASE_LOW    = 3'd2;
   localparam logic [2:0] REG_CV_BASE_MID    = 3'd3;
   localparam logic [2:0] REG_CV_BASE_HIGH   = 3'd4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [4:0] TICKS_PER_STEP_RST = 5'd6;
   localparam logic [4:0] GATE_OFF_TICK_RST  = 5'd4;
   localparam logic [7:0] CV_BASE_LOW_RST    = 8'd0;
   localparam logic [7:0] CV_BASE_MID_RST    = 8'd12;
   localparam logic [7:0] CV_BASE_HIGH_RST   = 8'd24;

   // pattern entry: flags in the low bits, note above
   localparam int ENTRY_W     = 10;
   localparam int FLAG_ON     = 0;
   localparam int FLAG_UP     = 1;
   localparam int FLAG_DOWN   = 2;
   localparam int FLAG_ACCENT = 3;
   localparam int FLAG_SLIDE  = 4;
   localparam int FLAG_LAST   = 5;
   localparam int NOTE_LSB    = 6;

   // fixed key-bank widths
   localparam int PAT_KEYS_W  = 8;
   localparam int NOTE_KEYS_W = 13;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [0:0] {
      ST_CLEAR,
      ST_READY
   } state_type;

   typedef struct packed {
      logic [4:0] ticks_per_step;
      logic [4:0] gate_off_tick;
      logic [7:0] cv_base_low;
      logic [7:0] cv_base_mid;
      logic [7:0] cv_base_high;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic        run_key;
      logic        note_mode_key;
      logic [7:0]  pattern_keys;
      logic [12:0] note_keys;
      logic        up_key;
      logic        down_key;
      logic [2:0]  wr_pattern;
      logic [4:0]  wr_step;
      logic [3:0]  wr_note;
      logic [5:0]  wr_flags;
   } req_type;

   // declared high to low so that gate lands in bit 0
   typedef struct packed {
      logic       keyboard_active;
      logic       tempo_led;
      logic [4:0] cur_step;
      logic [2:0] queued_pattern;
      logic [2:0] cur_pattern;
      logic       running;
      logic [7:0] cv_index;
      logic       slide;
      logic       accent;
      logic       gate;
   } result_type;

   typedef struct packed {
      logic               we;
      logic [ENTRY_W-1:0] data;
   } mem_wr_type;

   // octave base plus note, saturating at the top of the cv table
   function automatic logic [7:0] octave_cv(input logic up, input logic down,
                                            input logic [3:0] note, input cfg_type cfg);
      logic [7:0] base;
      logic [8:0] sum;
      if (up) begin
         base = cfg.cv_base_high;
      end else if (down) begin
         base = cfg.cv_base_low;
      end else begin
         base = cfg.cv_base_mid;
      end
      sum = {1'b0, base} + {5'b0, note};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

endpackage

// File: sv/sps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sps_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/sps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_core
// sequencer state, tick/scan/write decode and pattern store addressing
// ----------------------------------------------------------------------------
module sps_core #(
   parameter int PATTERNS   = 8,
   parameter int STEP_LIMIT = 17,
   parameter int NOTE_KEYS  = 13,
   parameter int ADDR_W     = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  sps_pkg::req_type              req,
   input  sps_pkg::cfg_type              cfg,
   input  logic [sps_pkg::ENTRY_W-1:0]   entry,
   output logic [ADDR_W-1:0]             rd_addr,
   output sps_pkg::mem_wr_type           wr,
   output logic [ADDR_W-1:0]             wr_addr,
   output sps_pkg::result_type           result
);
   import sps_pkg::*;

   localparam int STEPS  = STEP_LIMIT - 1;
   localparam int STEP_W = $clog2(STEP_LIMIT);

   function automatic logic [ADDR_W-1:0] store_addr(input int pat, input int stp);
      return ADDR_W'(pat * STEPS + stp - 1);
   endfunction

   logic              run_ff, run_in;
   logic              rkprev_ff, rkprev_in;
   logic [2:0]        play_ff, play_in;
   logic [2:0]        queue_ff, queue_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [4:0]        tick_ff, tick_in;
   logic              blink_ff, blink_in;
   logic              tempo_ff, tempo_in;
   logic              gate_ff, gate_in;
   logic              accent_ff, accent_in;
   logic              slide_ff, slide_in;
   logic [7:0]        cv_ff, cv_in;
   logic              kb_active;

   always_comb begin
      logic [5:0]      t_sum;
      logic [STEP_W:0] step_nx;
      logic            on;
      logic            sl;
      logic            chain;
      logic            pk_hit;
      logic [2:0]      pk_idx;
      logic            nk_hit;
      logic [3:0]      nk_idx;

      run_in    = run_ff;
      rkprev_in = rkprev_ff;
      play_in   = play_ff;
      queue_in  = queue_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      blink_in  = blink_ff;
      tempo_in  = tempo_ff;
      gate_in   = gate_ff;
      accent_in = accent_ff;
      slide_in  = slide_ff;
      cv_in     = cv_ff;
      kb_active = 1'b0;
      wr.we     = 1'b0;
      wr.data   = {req.wr_note, req.wr_flags};
      wr_addr   = store_addr(int'(req.wr_pattern), int'(req.wr_step));
      on        = entry[FLAG_ON];
      sl        = entry[FLAG_SLIDE];
      chain     = 1'b0;
      t_sum     = {1'b0, tick_ff} + 6'd1;
      step_nx   = {1'b0, step_ff} + (STEP_W+1)'(1);

      // lowest pattern key, highest note key
      pk_hit = 1'b0;
      pk_idx = 3'd0;
      for (int i = PAT_KEYS_W - 1; i >= 0; i--) begin
         if (req.pattern_keys[i] && i < PATTERNS) begin
            pk_hit = 1'b1;
            pk_idx = 3'(i);
         end
      end
      nk_hit = 1'b0;
      nk_idx = 4'd0;
      for (int i = 0; i < NOTE_KEYS_W; i++) begin
         if (req.note_keys[i] && i < NOTE_KEYS) begin
            nk_hit = 1'b1;
            nk_idx = 4'(i);
         end
      end

      if (accept) begin
         unique case (req.func)
            FUNC_TICK: begin
               if (t_sum > {1'b0, cfg.ticks_per_step}) begin
                  t_sum    = 6'd1;
                  blink_in = ~blink_ff;
                  // tempo flips when the half phase wraps back to zero
                  if (blink_ff) begin
                     tempo_in = ~tempo_ff;
                  end
               end
               tick_in = t_sum[4:0];
               if (run_ff) begin
                  if (tick_in == 5'd1) begin
                     gate_in = on;
                     if (on) begin
                        accent_in = entry[FLAG_ACCENT];
                        slide_in  = sl;
                        cv_in     = octave_cv(entry[FLAG_UP], entry[FLAG_DOWN],
                                              entry[NOTE_LSB +: 4], cfg);
                     end else begin
                        accent_in = 1'b0;
                        slide_in  = 1'b0;
                     end
                  end
                  if (tick_in == cfg.gate_off_tick && on && !sl) begin
                     gate_in   = 1'b0;
                     accent_in = 1'b0;
                  end
                  if (tick_in == cfg.ticks_per_step) begin
                     if (entry[FLAG_LAST]) begin
                        step_in = STEP_W'(1);
                        chain   = 1'b1;
                     end else if (step_nx >= (STEP_W+1)'(STEP_LIMIT)) begin
                        step_in = STEP_W'(1);
                        chain   = 1'b1;
                     end else begin
                        step_in = step_nx[STEP_W-1:0];
                     end
                     if (chain) begin
                        play_in = queue_ff;
                     end
                  end
               end
            end
            FUNC_SCAN: begin
               if (!rkprev_ff && req.run_key) begin
                  run_in  = ~run_ff;
                  step_in = STEP_W'(1);
                  tick_in = 5'd1;
               end
               rkprev_in = req.run_key;
               if (run_in) begin
                  if (pk_hit) begin
                     queue_in = pk_idx;
                  end
               end else if (req.note_mode_key) begin
                  if (nk_hit) begin
                     cv_in = octave_cv(req.up_key, req.down_key, nk_idx, cfg);
                  end
                  gate_in   = nk_hit;
                  kb_active = 1'b1;
               end else begin
                  gate_in = 1'b0;
                  if (pk_hit) begin
                     play_in  = pk_idx;
                     queue_in = pk_idx;
                  end
               end
            end
            FUNC_WRITE: begin
               wr.we = (int'(req.wr_pattern) < PATTERNS) && (req.wr_step != 5'd0) &&
                       (int'(req.wr_step) < STEP_LIMIT);
            end
            default: begin
            end
         endcase
      end
   end

   // prefetch the entry of the step that is current after this cycle
   assign rd_addr = store_addr(int'(play_in), int'(step_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         rkprev_ff <= 1'b0;
         play_ff   <= 3'd0;
         queue_ff  <= 3'd0;
         step_ff   <= STEP_W'(1);
         tick_ff   <= 5'd1;
         blink_ff  <= 1'b0;
         tempo_ff  <= 1'b1;
         gate_ff   <= 1'b0;
         accent_ff <= 1'b0;
         slide_ff  <= 1'b0;
         cv_ff     <= 8'd0;
      end else begin
         run_ff    <= run_in;
         rkprev_ff <= rkprev_in;
         play_ff   <= play_in;
         queue_ff  <= queue_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         blink_ff  <= blink_in;
         tempo_ff  <= tempo_in;
         gate_ff   <= gate_in;
         accent_ff <= accent_in;
         slide_ff  <= slide_in;
         cv_ff     <= cv_in;
      end
   end

   always_comb begin
      result.gate            = gate_in;
      result.accent          = accent_in;
      result.slide           = slide_in;
      result.cv_index        = cv_in;
      result.running         = run_in;
      result.cur_pattern     = play_in;
      result.queued_pattern  = queue_in;
      result.cur_step        = 5'(step_in);
      result.tempo_led       = tempo_in;
      result.keyboard_active = kb_active;
   end

endmodule

// File: sv/step_sequencer_pattern_play.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_pattern_play
// pattern-play step sequencer with stream in/out and apb register port
// ----------------------------------------------------------------------------
// Takes one item per clock (tick, panel scan or step write) while req_tready
// is high and returns one result beat per item, registered, in the cycle
// after the item is taken; a held result does not stop the next item unless
// it is still waiting when the following one would overwrite it. The pattern
// store sits in a single ram with a registered read; the entry of the step
// that plays next is fetched ahead whenever the play position changes, and a
// write to that same entry is forwarded. After reset the store is zeroed
// one entry per cycle, PATTERNS*(STEP_LIMIT-1) entries (128 by default), and
// req_tready stays low until then; register writes are taken throughout.
module step_sequencer_pattern_play #(
   parameter int PATTERNS   = 8,
   parameter int STEP_LIMIT = 17,
   parameter int NOTE_KEYS  = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   // tuser: func[1:0]
   // tdata: run_key, note_mode_key, pattern_keys[7:0], note_keys[12:0],
   //        up_key, down_key, wr_pattern[2:0], wr_step[4:0], wr_note[3:0],
   //        wr_flags[5:0], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,
   // tdata: gate, accent, slide, cv_index[7:0], running, cur_pattern[2:0],
   //        queued_pattern[2:0], cur_step[4:0], tempo_led, keyboard_active,
   //        zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sps_pkg::*;

   localparam int DEPTH  = PATTERNS * (STEP_LIMIT - 1);
   localparam int ADDR_W = $clog2(DEPTH);

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       csr_wr;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_TICKS_PER_STEP: cfg_in.ticks_per_step = csr_pwdata[4:0];
            REG_GATE_OFF_TICK:  cfg_in.gate_off_tick  = csr_pwdata[4:0];
            REG_CV_BASE_LOW:    cfg_in.cv_base_low    = csr_pwdata[7:0];
            REG_CV_BASE_MID:    cfg_in.cv_base_mid    = csr_pwdata[7:0];
            REG_CV_BASE_HIGH:   cfg_in.cv_base_high   = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TICKS_PER_STEP: csr_prdata = {27'd0, cfg_ff.ticks_per_step};
         REG_GATE_OFF_TICK:  csr_prdata = {27'd0, cfg_ff.gate_off_tick};
         REG_CV_BASE_LOW:    csr_prdata = {24'd0, cfg_ff.cv_base_low};
         REG_CV_BASE_MID:    csr_prdata = {24'd0, cfg_ff.cv_base_mid};
         REG_CV_BASE_HIGH:   csr_prdata = {24'd0, cfg_ff.cv_base_high};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_step <= TICKS_PER_STEP_RST;
         cfg_ff.gate_off_tick  <= GATE_OFF_TICK_RST;
         cfg_ff.cv_base_low    <= CV_BASE_LOW_RST;
         cfg_ff.cv_base_mid    <= CV_BASE_MID_RST;
         cfg_ff.cv_base_high   <= CV_BASE_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------
   // store clearing after reset
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_active;
   logic              clr_last;

   assign clr_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_CLEAR: clr_active = 1'b1;
         ST_READY: clr_active = 1'b0;
      endcase
   end

   assign clr_cnt_in = clr_active ? clr_cnt_ff + ADDR_W'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // input decode and core
   // ------------------------------------------------------------------
   req_type            req;
   logic               accept;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic [ENTRY_W-1:0] entry;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  core_wr_addr;
   mem_wr_type         core_wr;

   always_comb begin
      req.func          = req_tuser;
      req.run_key       = req_tdata[0];
      req.note_mode_key = req_tdata[1];
      req.pattern_keys  = req_tdata[9:2];
      req.note_keys     = req_tdata[22:10];
      req.up_key        = req_tdata[23];
      req.down_key      = req_tdata[24];
      req.wr_pattern    = req_tdata[27:25];
      req.wr_step       = req_tdata[32:28];
      req.wr_note       = req_tdata[36:33];
      req.wr_flags      = req_tdata[42:37];
   end

   assign req_tready = !clr_active && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   sps_core #(
      .PATTERNS   (PATTERNS),
      .STEP_LIMIT (STEP_LIMIT),
      .NOTE_KEYS  (NOTE_KEYS),
      .ADDR_W     (ADDR_W)
   ) u_sps_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req),
      .cfg     (cfg_ff),
      .entry   (entry),
      .rd_addr (rd_addr),
      .wr      (core_wr),
      .wr_addr (core_wr_addr),
      .result  (rsp_data_in)
   );

   // ------------------------------------------------------------------
   // pattern store with write forwarding
   // ------------------------------------------------------------------
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               fwd_hit_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;

   assign ram_we    = clr_active || core_wr.we;
   assign ram_waddr = clr_active ? clr_cnt_ff : core_wr_addr;
   assign ram_wdata = clr_active ? '0 : core_wr.data;

   sps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_sps_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // ram reads old data on a same-address write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= ram_we && (ram_waddr == rd_addr);
      end
      fwd_data_ff <= ram_wdata;
   end

   assign entry = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(result_type))'(0), rsp_data_ff};

endmodule

// File: sv/sps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// port-level checks on the step sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sps_pkg::*;

   localparam int RUN_BIT = 11;
   localparam int KB_BIT  = 24;

   // a stalled result beat holds
   `SPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // every input beat yields a result beat in the next cycle
   `SPS_ASSERT_NXT(a_req_to_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // no input beat while a result is stuck
   `SPS_ASSERT_IMP(a_no_overrun, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // keyboard play only happens while stopped
   `SPS_ASSERT_IMP(a_kb_stopped, clock, reset, rsp_tvalid && rsp_tdata[KB_BIT], !rsp_tdata[RUN_BIT])

endmodule

bind step_sequencer_pattern_play sps_checker u_sps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
